/* sv/rtp_header_extension_id_map_defines.svh */
// ---------------------------------------------------------------------------
// rtp header extension id map - assertion macros
// shared macros for the concurrent checks of the id map block
// ---------------------------------------------------------------------------
`ifndef RTP_HEADER_EXTENSION_ID_MAP_DEFINES_SVH
`define RTP_HEADER_EXTENSION_ID_MAP_DEFINES_SVH

// plain property, checked outside reset
`define RTP_EXT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rtp_ext assertion failed");

// implication, checked outside reset
`define RTP_EXT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtp_ext implication failed");

`endif

/* sv/rtp_ext_pkg.sv */
// ---------------------------------------------------------------------------
// rtp_ext_pkg
// types, codes and constants of the rtp header extension id map
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtp_ext_pkg;

   localparam int DEFAULT_NUM_TYPES = 16;

   localparam int REQ_TYPE_W   = 3;
   localparam int EXT_TYPE_W   = 4;
   localparam int EXT_ID_W     = 8;
   localparam int EXT_SIZE_W   = 8;
   localparam int STATUS_W     = 3;
   localparam int BLOCK_SIZE_W = 12;
   localparam int COUNT_W      = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER    = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DEREGISTER  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ID_BY_TYPE  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_TYPE_BY_ID  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_SIZE_ITEM   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ID_TAKEN  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // csr register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALID_ID       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_BYTE_MAX_ID    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_BYTE_MAX_VSIZE = 2'd2;

   localparam logic [CSR_DATA_W-1:0] MAX_VALID_ID_RESET       = 8'd255;
   localparam logic [CSR_DATA_W-1:0] ONE_BYTE_MAX_ID_RESET    = 8'd14;
   localparam logic [CSR_DATA_W-1:0] ONE_BYTE_MAX_VSIZE_RESET = 8'd16;

   localparam logic [BLOCK_SIZE_W-1:0] PAYLOAD_MAX        = 12'hFFF;
   localparam logic [COUNT_W-1:0]      COUNT_MAX          = 5'd31;
   localparam logic [BLOCK_SIZE_W:0]   BLOCK_HEADER_BYTES = 13'd4;
   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_SAT     = 12'd4092;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SCAN,
      S_FINAL,
      S_RESP
   } state_type;

endpackage

/* sv/rtp_ext_req_if.sv */
// ---------------------------------------------------------------------------
// rtp_ext_req_if
// request channel of the id map: valid/ready with request payload
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtp_ext_req_if import rtp_ext_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [EXT_TYPE_W-1:0] ext_type;
   logic [EXT_ID_W-1:0]   ext_id;
   logic [EXT_SIZE_W-1:0] ext_size;
   logic                  last_item;

   modport source (
      output valid, req_type, ext_type, ext_id, ext_size, last_item,
      input  ready
   );

   modport sink (
      input  valid, req_type, ext_type, ext_id, ext_size, last_item,
      output ready
   );
endinterface

/* sv/rtp_ext_rsp_if.sv */
// ---------------------------------------------------------------------------
// rtp_ext_rsp_if
// response channel of the id map: valid/ready with response payload
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtp_ext_rsp_if import rtp_ext_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [EXT_ID_W-1:0]     found_id;
   logic [EXT_TYPE_W-1:0]   found_type;
   logic [BLOCK_SIZE_W-1:0] block_size;

   modport source (
      output valid, status, found_id, found_type, block_size,
      input  ready
   );

   modport sink (
      input  valid, status, found_id, found_type, block_size,
      output ready
   );
endinterface

/* sv/rtp_ext_table.sv */
// ---------------------------------------------------------------------------
// rtp_ext_table
// id-of-type store: one write port, one registered read port, valid bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_ext_table import rtp_ext_pkg::*; #(
   parameter int NUM_TYPES = DEFAULT_NUM_TYPES,
   localparam int TIDX_W   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [TIDX_W-1:0]   rd_addr,
   output logic [EXT_ID_W-1:0] rd_entry,
   input  logic                wr_en,
   input  logic [TIDX_W-1:0]   wr_addr,
   input  logic [EXT_ID_W-1:0] wr_data
);

   logic [EXT_ID_W-1:0]  mem_ff [NUM_TYPES];
   logic [NUM_TYPES-1:0] valid_ff;
   logic [EXT_ID_W-1:0]  rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* sv/rtp_header_extension_id_map.sv */
// ---------------------------------------------------------------------------
// rtp_header_extension_id_map
// extension type to wire id table with lookups and block size accumulation
// ---------------------------------------------------------------------------
// Requests enter on req (valid/ready) and results leave on rsp (valid/ready).
// The csr port writes max_valid_id, one_byte_max_id and
// one_byte_max_value_size; write only while no request is in flight.
// One request is handled at a time; req.ready is high only in idle.
// Register and type-by-id lookup scan the table one entry per cycle through
// a single registered read port, from entry 1 up to the matching type or
// the last entry, and answer when the scan ends. Deregister and id-by-type
// lookup read the addressed entry in the read state and answer from it.
// Size items of a valid type pass the read state; those without the last
// flag give no result and free the block, the last one passes the final
// state and answers. Bad requests answer straight from decode.
// A new request is taken only once the current one is finished.
// A result stays in the rsp register while the receiver stalls; the next
// request is taken the cycle after the result is taken.
// Reset (synchronous) clears the table through per-entry valid bits and the
// size accumulators, and sets the csr registers to their reset values at once; no clearing pass is run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtp_header_extension_id_map_defines.svh"

module rtp_header_extension_id_map import rtp_ext_pkg::*; #(
   parameter int NUM_TYPES = DEFAULT_NUM_TYPES
) (
   input  logic                   clock,
   input  logic                   reset,
   rtp_ext_req_if.sink            req,
   rtp_ext_rsp_if.source          rsp,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int CMP_W  = (TIDX_W + 1 > EXT_TYPE_W) ? TIDX_W + 1 : EXT_TYPE_W + 1;
   localparam logic [TIDX_W-1:0] LAST_T = TIDX_W'(NUM_TYPES - 1);

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] max_valid_id_ff;
   logic [CSR_DATA_W-1:0] one_byte_max_id_ff;
   logic [CSR_DATA_W-1:0] one_byte_max_vsize_ff;

   logic [REQ_TYPE_W-1:0] op_ff;
   logic [EXT_TYPE_W-1:0] type_ff;
   logic [EXT_ID_W-1:0]   id_ff;
   logic [EXT_SIZE_W-1:0] size_ff;
   logic                  last_ff;

   logic [TIDX_W-1:0] scan_ff, scan_in;

   logic [BLOCK_SIZE_W-1:0] sum_ff, sum_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    two_ff, two_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [EXT_ID_W-1:0]     rsp_found_id_ff, rsp_found_id_in;
   logic [EXT_TYPE_W-1:0]   rsp_found_type_ff, rsp_found_type_in;
   logic [BLOCK_SIZE_W-1:0] rsp_block_size_ff, rsp_block_size_in;

   logic [TIDX_W-1:0]   tbl_rd_addr;
   logic [EXT_ID_W-1:0] tbl_rd_entry;
   logic                tbl_wr_en;
   logic [EXT_ID_W-1:0] tbl_wr_data;

   logic [TIDX_W-1:0]     type_idx;
   logic                  type_ok;
   logic                  id_ok;
   logic                  scan_hit;
   logic                  scan_end;
   logic [TIDX_W-1:0]     holder;
   logic [BLOCK_SIZE_W:0] sum_wide;
   logic [COUNT_W:0]      hdr_bytes;
   logic [BLOCK_SIZE_W:0] total;
   logic [BLOCK_SIZE_W+1:0] rounded;
   logic [BLOCK_SIZE_W-1:0] block;

   assign type_idx = TIDX_W'(type_ff);
   assign type_ok  = (type_ff != '0) && (CMP_W'(type_ff) < CMP_W'(NUM_TYPES));
   assign id_ok    = (id_ff != '0) && (id_ff <= max_valid_id_ff);
   assign scan_hit = (tbl_rd_entry == id_ff);
   assign scan_end = scan_hit || (scan_ff == LAST_T);
   assign holder   = scan_hit ? scan_ff : '0;

   // block size: 4 + header bytes + payload, rounded up to 4; zero without payload, 4092 on overflow
   assign sum_wide  = {1'b0, sum_ff} + {{(BLOCK_SIZE_W + 1 - EXT_SIZE_W){1'b0}}, size_ff};
   assign hdr_bytes = two_ff ? {count_ff, 1'b0} : {1'b0, count_ff};
   assign total     = BLOCK_HEADER_BYTES + (BLOCK_SIZE_W + 1)'(hdr_bytes)
                      + {1'b0, sum_ff};
   assign rounded   = ({1'b0, total} + (BLOCK_SIZE_W + 2)'(3)) & ~(BLOCK_SIZE_W + 2)'(3);
   assign block     = (sum_ff == '0) ? '0 :
                      (rounded > (BLOCK_SIZE_W + 2)'(PAYLOAD_MAX)) ? BLOCK_SIZE_SAT :
                      rounded[BLOCK_SIZE_W-1:0];

   rtp_ext_table #(
      .NUM_TYPES (NUM_TYPES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (tbl_rd_addr),
      .rd_entry (tbl_rd_entry),
      .wr_en    (tbl_wr_en),
      .wr_addr  (type_idx),
      .wr_data  (tbl_wr_data)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.found_id   = rsp_found_id_ff;
   assign rsp.found_type = rsp_found_type_ff;
   assign rsp.block_size = rsp_block_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_valid_id_ff       <= MAX_VALID_ID_RESET;
         one_byte_max_id_ff    <= ONE_BYTE_MAX_ID_RESET;
         one_byte_max_vsize_ff <= ONE_BYTE_MAX_VSIZE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_VALID_ID:       max_valid_id_ff       <= csr_wdata;
            CSR_ONE_BYTE_MAX_ID:    one_byte_max_id_ff    <= csr_wdata;
            CSR_ONE_BYTE_MAX_VSIZE: one_byte_max_vsize_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff   <= req.req_type;
         type_ff <= req.ext_type;
         id_ff   <= req.ext_id;
         size_ff <= req.ext_size;
         last_ff <= req.last_item;
      end
      scan_ff           <= scan_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_found_id_ff   <= rsp_found_id_in;
      rsp_found_type_ff <= rsp_found_type_in;
      rsp_block_size_ff <= rsp_block_size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         two_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         two_ff       <= two_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      scan_in           = scan_ff;
      sum_in            = sum_ff;
      count_in          = count_ff;
      two_in            = two_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_found_id_in   = rsp_found_id_ff;
      rsp_found_type_in = rsp_found_type_ff;
      rsp_block_size_in = rsp_block_size_ff;
      tbl_rd_addr       = type_idx;
      tbl_wr_en         = 1'b0;
      tbl_wr_data       = id_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rsp_status_in     = STATUS_OK;
            rsp_found_id_in   = '0;
            rsp_found_type_in = '0;
            rsp_block_size_in = '0;
            case (op_ff)
               REQ_REGISTER: begin
                  if (!type_ok) begin
                     rsp_status_in = STATUS_BAD_TYPE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else if (!id_ok) begin
                     rsp_status_in = STATUS_BAD_ID;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else begin
                     tbl_rd_addr = TIDX_W'(1);
                     scan_in     = TIDX_W'(1);
                     state_in    = S_SCAN;
                  end
               end
               REQ_TYPE_BY_ID: begin
                  if (!id_ok) begin
                     rsp_status_in = STATUS_BAD_ID;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else begin
                     tbl_rd_addr = TIDX_W'(1);
                     scan_in     = TIDX_W'(1);
                     state_in    = S_SCAN;
                  end
               end
               REQ_DEREGISTER, REQ_ID_BY_TYPE: begin
                  if (!type_ok) begin
                     rsp_status_in = STATUS_BAD_TYPE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_READ;
                  end
               end
               REQ_SIZE_ITEM: begin
                  if (type_ok) begin
                     state_in = S_READ;
                  end else if (last_ff) begin
                     state_in = S_FINAL;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_READ: begin
            case (op_ff)
               REQ_DEREGISTER, REQ_ID_BY_TYPE: begin
                  rsp_found_id_in = tbl_rd_entry;
                  rsp_status_in   = (tbl_rd_entry == '0) ? STATUS_NOT_FOUND : STATUS_OK;
                  tbl_wr_en       = (op_ff == REQ_DEREGISTER);
                  tbl_wr_data     = '0;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_RESP;
               end
               REQ_SIZE_ITEM: begin
                  // only registered types count
                  if (tbl_rd_entry != '0) begin
                     if ((tbl_rd_entry > one_byte_max_id_ff) ||
                         (size_ff > one_byte_max_vsize_ff)) begin
                        two_in = 1'b1;
                     end
                     sum_in   = sum_wide[BLOCK_SIZE_W] ? PAYLOAD_MAX
                                                       : sum_wide[BLOCK_SIZE_W-1:0];
                     count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
                  end
                  state_in = last_ff ? S_FINAL : S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_SCAN: begin
            // read of the next entry overlaps the compare of this one
            tbl_rd_addr = (scan_ff == LAST_T) ? scan_ff : scan_ff + 1'b1;
            scan_in     = scan_ff + 1'b1;
            if (scan_end) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
               if (op_ff == REQ_REGISTER) begin
                  if ((holder != '0) && (CMP_W'(holder) != CMP_W'(type_ff))) begin
                     rsp_status_in     = STATUS_ID_TAKEN;
                     rsp_found_type_in = EXT_TYPE_W'(holder);
                  end else begin
                     tbl_wr_en   = 1'b1;
                     tbl_wr_data = id_ff;
                  end
               end else begin
                  rsp_found_type_in = EXT_TYPE_W'(holder);
                  rsp_status_in     = (holder == '0) ? STATUS_NOT_FOUND : STATUS_OK;
               end
            end
         end

         S_FINAL: begin
            rsp_status_in     = STATUS_OK;
            rsp_found_id_in   = '0;
            rsp_found_type_in = '0;
            rsp_block_size_in = block;
            sum_in            = '0;
            count_in          = '0;
            two_in            = 1'b0;
            rsp_valid_in      = 1'b1;
            state_in          = S_RESP;
         end

         S_RESP: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   `RTP_EXT_ASSERT_IMPL(a_ready_no_rsp, clock, reset, req.ready, !rsp.valid)
   `RTP_EXT_ASSERT_IMPL(a_block_aligned, clock, reset, rsp.valid, rsp.block_size[1:0] == 2'b00)
   `RTP_EXT_ASSERT_IMPL(a_taken_has_holder, clock, reset,
      rsp.valid && (rsp.status == STATUS_ID_TAKEN), rsp.found_type != '0)
   `RTP_EXT_ASSERT_IMPL(a_scan_in_range, clock, reset, state_ff == S_SCAN, scan_ff != '0)
   `RTP_EXT_ASSERT(a_rsp_only_after_work, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) != S_IDLE))

endmodule
